// ----- design/psfq_pkg.sv -----
// shared types, constants and codes for the priority select fifo queue
`default_nettype none
package psfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  priority_level;
      logic [15:0] arrival;
   } entry_type;

   // running result handed from cell to cell during the scan
   typedef struct packed {
      logic        any;
      logic [15:0] earliest;
      logic        first_found;
      logic [15:0] first_id;
      logic        best_found;
      logic [15:0] best_id;
      logic [7:0]  best_priority;
      logic [15:0] best_arrival;
   } acc_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_PUSH,
      CMD_SHIFT,
      CMD_COMPACT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic         occupied;
      logic         tail;
   } cell_ctl_type;

   localparam entry_type ENTRY_EMPTY = '{default: '0};
   localparam acc_type   ACC_EMPTY   = '{default: '0};

endpackage
`default_nettype wire

// ----- design/psfq_cell.sv -----
// one queue slot with its share of the compaction and the scan accumulator
`default_nettype none
module psfq_cell (
   input  wire                     clock,
   input  psfq_pkg::cell_ctl_type  ctl,
   input  psfq_pkg::entry_type     new_entry,
   input  psfq_pkg::entry_type     right_entry,
   input  wire  [15:0]             remove_id,
   input  wire  [15:0]             query_time,
   input  wire                     seen_in,
   output logic                    seen_out,
   input  psfq_pkg::acc_type       prev_acc,
   output psfq_pkg::entry_type     slot_out,
   output psfq_pkg::acc_type       acc_out
);

   psfq_pkg::entry_type slot_ff, slot_in;
   psfq_pkg::acc_type   acc_ff, acc_in;
   logic                match;

   // a match here or anywhere toward the head pulls this slot left
   assign match    = ctl.occupied && (slot_ff.id == remove_id);
   assign seen_out = seen_in | match;

   always_comb begin
      slot_in = slot_ff;
      case (ctl.cmd)
         psfq_pkg::CMD_PUSH: begin
            if (ctl.tail) slot_in = new_entry;
         end
         psfq_pkg::CMD_SHIFT: begin
            slot_in = right_entry;
         end
         psfq_pkg::CMD_COMPACT: begin
            if (seen_out) slot_in = right_entry;
         end
         default: begin
            slot_in = slot_ff;
         end
      endcase
   end

   always_comb begin
      acc_in = prev_acc;
      if (ctl.occupied) begin
         acc_in.any = 1'b1;
         if (!prev_acc.any || slot_ff.arrival < prev_acc.earliest) begin
            acc_in.earliest = slot_ff.arrival;
         end
         if (!prev_acc.first_found && slot_ff.arrival <= query_time) begin
            acc_in.first_found = 1'b1;
            acc_in.first_id    = slot_ff.id;
         end
         if (slot_ff.id != 16'd0 &&
             (!prev_acc.best_found ||
              slot_ff.priority_level > prev_acc.best_priority ||
              (slot_ff.priority_level == prev_acc.best_priority &&
               slot_ff.arrival < prev_acc.best_arrival))) begin
            acc_in.best_found    = 1'b1;
            acc_in.best_id       = slot_ff.id;
            acc_in.best_priority = slot_ff.priority_level;
            acc_in.best_arrival  = slot_ff.arrival;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      acc_ff  <= acc_in;
   end

   assign slot_out = slot_ff;
   assign acc_out  = acc_ff;

endmodule
`default_nettype wire

// ----- design/priority_select_fifo_queue.sv -----
// top level: command sequencer, occupancy count and the row of queue cells
// A request is taken when start is high and busy is low. Push, pop and query pass
// through the apply step, then the scan, in which the result walks through the cell
// row, one cell per cycle, then the result register that drives rsp_strobe. A remove
// repeats the apply step once for each entry it deletes. busy drops in the cycle that
// carries rsp_strobe, so the next request can be taken there. The result is shown
// for exactly one cycle and cannot be held off by the receiver.
`default_nettype none
module priority_select_fifo_queue (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [1:0]  req_operation,
   input  wire  [15:0] req_entry_id,
   input  wire  [7:0]  req_entry_priority,
   input  wire  [15:0] req_entry_arrival,
   input  wire  [15:0] req_query_time,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_popped_id,
   output logic        rsp_best_found,
   output logic [15:0] rsp_best_id,
   output logic [15:0] rsp_earliest_arrival,
   output logic [15:0] rsp_first_arrived_id,
   output logic [4:0]  rsp_entry_count
);

   localparam int D = psfq_pkg::QUEUE_DEPTH;
   localparam int W = psfq_pkg::CNT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN
   } state_type;

   state_type                  state_ff;
   logic [1:0]                 op_ff;
   psfq_pkg::entry_type        new_ff;
   logic [15:0]                qt_ff;
   logic [W-1:0]               count_ff;
   logic [W-1:0]               scan_ff;
   logic [1:0]                 status_ff;
   logic [15:0]                popped_ff;
   logic                       strobe_ff;
   logic [1:0]                 rsp_status_ff;
   logic [15:0]                rsp_popped_ff;
   psfq_pkg::acc_type          rsp_acc_ff;
   logic [W-1:0]               rsp_count_ff;

   psfq_pkg::cell_cmd_type     cmd;
   psfq_pkg::cell_ctl_type     ctl [D];
   psfq_pkg::entry_type        slots [D];
   psfq_pkg::acc_type          accs [D];
   logic [D:0]                 seen;
   logic                       full, empty, accept, any_match;
   logic [W+4:0]               count_ext;

   assign accept    = start && (state_ff == S_IDLE);
   assign full      = (count_ff == W'(D));
   assign empty     = (count_ff == '0);
   assign any_match = seen[D];
   assign seen[0]   = 1'b0;

   always_comb begin
      cmd = psfq_pkg::CMD_HOLD;
      if (state_ff == S_EXEC) begin
         case (op_ff)
            psfq_pkg::OP_PUSH:   if (!full) cmd = psfq_pkg::CMD_PUSH;
            psfq_pkg::OP_POP:    if (!empty) cmd = psfq_pkg::CMD_SHIFT;
            psfq_pkg::OP_REMOVE: cmd = psfq_pkg::CMD_COMPACT;
            default:             cmd = psfq_pkg::CMD_HOLD;
         endcase
      end
   end

   for (genvar i = 0; i < D; i++) begin : g_cell
      psfq_pkg::entry_type right;
      psfq_pkg::acc_type   prev;

      assign ctl[i].cmd      = cmd;
      assign ctl[i].occupied = (W'(i) < count_ff);
      assign ctl[i].tail     = (W'(i) == count_ff);

      if (i == D - 1) begin : g_last
         assign right = psfq_pkg::ENTRY_EMPTY;
      end else begin : g_mid
         assign right = slots[i+1];
      end

      if (i == 0) begin : g_head
         assign prev = psfq_pkg::ACC_EMPTY;
      end else begin : g_body
         assign prev = accs[i-1];
      end

      psfq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl[i]),
         .new_entry   (new_ff),
         .right_entry (right),
         .remove_id   (new_ff.id),
         .query_time  (qt_ff),
         .seen_in     (seen[i]),
         .seen_out    (seen[i+1]),
         .prev_acc    (prev),
         .slot_out    (slots[i]),
         .acc_out     (accs[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff                 <= req_operation;
                  new_ff.id             <= req_entry_id;
                  new_ff.priority_level <= req_entry_priority;
                  new_ff.arrival        <= req_entry_arrival;
                  qt_ff                 <= req_query_time;
                  status_ff             <= psfq_pkg::ST_OK;
                  popped_ff             <= 16'd0;
                  state_ff              <= S_EXEC;
               end
            end
            S_EXEC: begin
               scan_ff  <= '0;
               state_ff <= S_SCAN;
               case (op_ff)
                  psfq_pkg::OP_PUSH: begin
                     if (full) status_ff <= psfq_pkg::ST_FULL;
                     else      count_ff  <= count_ff + W'(1);
                  end
                  psfq_pkg::OP_POP: begin
                     if (empty) begin
                        status_ff <= psfq_pkg::ST_EMPTY;
                     end else begin
                        popped_ff <= slots[0].id;
                        count_ff  <= count_ff - W'(1);
                     end
                  end
                  psfq_pkg::OP_REMOVE: begin
                     // one matching entry leaves per cycle until none remain
                     if (any_match) begin
                        count_ff <= count_ff - W'(1);
                        state_ff <= S_EXEC;
                     end
                  end
                  default: begin
                     state_ff <= S_SCAN;
                  end
               endcase
            end
            S_SCAN: begin
               scan_ff <= scan_ff + W'(1);
               // last cell holds the full result once every cell has refilled
               if (scan_ff == W'(D)) begin
                  rsp_status_ff <= status_ff;
                  rsp_popped_ff <= popped_ff;
                  rsp_acc_ff    <= accs[D-1];
                  rsp_count_ff  <= count_ff;
                  strobe_ff     <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign count_ext            = {5'd0, rsp_count_ff};
   assign busy                 = (state_ff != S_IDLE);
   assign rsp_strobe           = strobe_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_popped_id        = rsp_popped_ff;
   assign rsp_best_found       = rsp_acc_ff.best_found;
   assign rsp_best_id          = rsp_acc_ff.best_id;
   assign rsp_earliest_arrival = rsp_acc_ff.earliest;
   assign rsp_first_arrived_id = rsp_acc_ff.first_id;
   assign rsp_entry_count      = count_ext[4:0];

endmodule
`default_nettype wire

// ----- sim/priority_select_fifo_queue_tb.sv -----
// self-checking testbench for the priority select fifo queue
module priority_select_fifo_queue_tb;
   import psfq_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
   localparam int RANDOM_ITEMS = 1100;
   localparam int PRINT_LIMIT  = 40;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] popped_id;
      logic        best_found;
      logic [15:0] best_id;
      logic [15:0] earliest_arrival;
      logic [15:0] first_arrived_id;
      logic [4:0]  entry_count;
   } queue_result_t;

   typedef struct packed {
      logic [1:0]    op;
      logic [15:0]   id;
      logic [7:0]    prio;
      logic [15:0]   arrival;
      logic [15:0]   query_time;
      logic          typed;
      queue_result_t result;
   } request_row_t;

   localparam queue_result_t UNTYPED    = '0;
   localparam queue_result_t EMPTY_OK   =
      {ST_OK, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 5'd0};
   localparam queue_result_t EMPTY_POP  =
      {ST_EMPTY, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 5'd0};
   localparam queue_result_t FIRST_PUSH =
      {ST_OK, 16'h0000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd1};

   // empty-queue cases, fill to full with ties and id 0 entries, then drain cases
   localparam request_row_t DIRECTED_ROWS [25] = '{
      {OP_POP,    16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1, EMPTY_POP},
      {OP_QUERY,  16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1, EMPTY_OK},
      {OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 16'hFFFF, 1'b1, EMPTY_OK},
      {OP_PUSH,   16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, FIRST_PUSH},
      {OP_PUSH,   16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, UNTYPED},
      {OP_PUSH,   16'h00AA, 8'h80, 16'h0300, 16'h0200, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0055, 8'hFF, 16'h0010, 16'hFFFF, 1'b0, UNTYPED},
      {OP_PUSH,   16'h00AA, 8'hFF, 16'h0010, 16'h0010, 1'b0, UNTYPED},
      {OP_PUSH,   16'h8000, 8'h01, 16'h8000, 16'h7FFF, 1'b0, UNTYPED},
      {OP_PUSH,   16'h00AA, 8'h7F, 16'h0001, 16'h0001, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0001, 8'hFF, 16'h0005, 16'h0000, 1'b0, UNTYPED},
      {OP_PUSH,   16'h00AA, 8'h00, 16'hFFFE, 16'h5555, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0002, 8'h55, 16'h1234, 16'h1234, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0003, 8'hAA, 16'h4321, 16'hAAAA, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0000, 8'hFF, 16'h0000, 16'h0000, 1'b0, UNTYPED},
      {OP_PUSH,   16'h00AA, 8'h80, 16'h0300, 16'h0300, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0004, 8'h10, 16'h0020, 16'h001F, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0005, 8'h20, 16'h0030, 16'h0030, 1'b0, UNTYPED},
      {OP_PUSH,   16'h0006, 8'h30, 16'h0040, 16'h0000, 1'b0, UNTYPED},
      {OP_PUSH,   16'h7777, 8'hFF, 16'h0000, 16'hFFFF, 1'b0, UNTYPED},
      {OP_REMOVE, 16'h00AA, 8'h00, 16'h0000, 16'h0100, 1'b0, UNTYPED},
      {OP_REMOVE, 16'h1234, 8'h00, 16'h0000, 16'h0100, 1'b0, UNTYPED},
      {OP_POP,    16'h0000, 8'h00, 16'h0000, 16'hFFFF, 1'b0, UNTYPED},
      {OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, UNTYPED},
      {OP_QUERY,  16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, UNTYPED}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = OP_QUERY;
   logic [15:0] req_entry_id = '0;
   logic [7:0]  req_entry_priority = '0;
   logic [15:0] req_entry_arrival = '0;
   logic [15:0] req_query_time = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_popped_id;
   logic        rsp_best_found;
   logic [15:0] rsp_best_id;
   logic [15:0] rsp_earliest_arrival;
   logic [15:0] rsp_first_arrived_id;
   logic [4:0]  rsp_entry_count;

   // typed expectation travels with the request it belongs to
   logic          req_typed = 1'b0;
   queue_result_t req_typed_result = '0;

   // predictor copy of the queue, slot 0 is the head
   logic [15:0] held_id [QUEUE_DEPTH];
   logic [7:0]  held_prio [QUEUE_DEPTH];
   logic [15:0] held_arrival [QUEUE_DEPTH];
   int          held_count = 0;

   queue_result_t expected_results [$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            idle_allowed = 1'b1;

   priority_select_fifo_queue i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_operation        (req_operation),
      .req_entry_id         (req_entry_id),
      .req_entry_priority   (req_entry_priority),
      .req_entry_arrival    (req_entry_arrival),
      .req_query_time       (req_query_time),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_popped_id        (rsp_popped_id),
      .rsp_best_found       (rsp_best_found),
      .rsp_best_id          (rsp_best_id),
      .rsp_earliest_arrival (rsp_earliest_arrival),
      .rsp_first_arrived_id (rsp_first_arrived_id),
      .rsp_entry_count      (rsp_entry_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic queue_result_t apply_queue_op(input logic [1:0] op,
                                                    input logic [15:0] id,
                                                    input logic [7:0] prio,
                                                    input logic [15:0] arrival,
                                                    input logic [15:0] query_time);
      queue_result_t res;
      int            kept;
      logic          first_found;
      logic [7:0]    best_prio;
      logic [15:0]   best_arrival;
      res = '0;
      kept = 0;
      first_found = 1'b0;
      best_prio = '0;
      best_arrival = '0;
      case (op)
         OP_PUSH: begin
            if (held_count >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               held_id[held_count] = id;
               held_prio[held_count] = prio;
               held_arrival[held_count] = arrival;
               held_count++;
            end
         end
         OP_POP: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.popped_id = held_id[0];
               for (int i = 1; i < held_count; i++) begin
                  held_id[i-1] = held_id[i];
                  held_prio[i-1] = held_prio[i];
                  held_arrival[i-1] = held_arrival[i];
               end
               held_count--;
            end
         end
         OP_REMOVE: begin
            // compact the survivors toward the head, order kept
            for (int i = 0; i < held_count; i++) begin
               if (held_id[i] != id) begin
                  held_id[kept] = held_id[i];
                  held_prio[kept] = held_prio[i];
                  held_arrival[kept] = held_arrival[i];
                  kept++;
               end
            end
            held_count = kept;
         end
         default: ;
      endcase
      for (int i = 0; i < held_count; i++) begin
         if (i == 0 || held_arrival[i] < res.earliest_arrival)
            res.earliest_arrival = held_arrival[i];
         if (!first_found && held_arrival[i] <= query_time) begin
            first_found = 1'b1;
            res.first_arrived_id = held_id[i];
         end
         // strict compares keep the entry nearest the head on a full tie
         if (held_id[i] != 16'h0000 && (!res.best_found || held_prio[i] > best_prio ||
             (held_prio[i] == best_prio && held_arrival[i] < best_arrival))) begin
            res.best_found = 1'b1;
            res.best_id = held_id[i];
            best_prio = held_prio[i];
            best_arrival = held_arrival[i];
         end
      end
      res.entry_count = 5'(held_count);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // call at the edge where the previous request was taken
   task automatic send_request(input logic [1:0] op, input logic [15:0] id,
                               input logic [7:0] prio, input logic [15:0] arrival,
                               input logic [15:0] query_time, input logic typed,
                               input queue_result_t typed_result);
      if (idle_allowed && $urandom_range(0, 99) < 10) begin
         // wait for the block to go idle so the pause leaves a real gap
         start <= 1'b0;
         do @(posedge clock); while (busy);
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_entry_id <= id;
      req_entry_priority <= prio;
      req_entry_arrival <= arrival;
      req_query_time <= query_time;
      req_typed <= typed;
      req_typed_result <= typed_result;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   always @(posedge clock) begin
      queue_result_t expected;
      queue_result_t predicted;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end else if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               expected = expected_results.pop_front();
               if (rsp_status !== expected.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, expected.status));
               if (rsp_popped_id !== expected.popped_id)
                  report_mismatch($sformatf("popped_id %h, expected %h",
                                            rsp_popped_id, expected.popped_id));
               if (rsp_best_found !== expected.best_found)
                  report_mismatch($sformatf("best_found %b, expected %b",
                                            rsp_best_found, expected.best_found));
               if (rsp_best_id !== expected.best_id)
                  report_mismatch($sformatf("best_id %h, expected %h",
                                            rsp_best_id, expected.best_id));
               if (rsp_earliest_arrival !== expected.earliest_arrival)
                  report_mismatch($sformatf("earliest_arrival %h, expected %h",
                                            rsp_earliest_arrival,
                                            expected.earliest_arrival));
               if (rsp_first_arrived_id !== expected.first_arrived_id)
                  report_mismatch($sformatf("first_arrived_id %h, expected %h",
                                            rsp_first_arrived_id,
                                            expected.first_arrived_id));
               if (rsp_entry_count !== expected.entry_count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_entry_count, expected.entry_count));
            end
         end
         if (start && !busy) begin
            predicted = apply_queue_op(req_operation, req_entry_id, req_entry_priority,
                                       req_entry_arrival, req_query_time);
            expected_results.push_back(req_typed ? req_typed_result : predicted);
         end
      end
   end

   initial begin
      int          mode;
      int          push_pct;
      int          pop_pct;
      int          remove_pct;
      int          pick;
      logic [1:0]  op;
      logic [15:0] id;
      logic [7:0]  prio;
      logic [15:0] arrival;
      logic [15:0] query_time;
      mode = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[row])
         send_request(DIRECTED_ROWS[row].op, DIRECTED_ROWS[row].id, DIRECTED_ROWS[row].prio,
                      DIRECTED_ROWS[row].arrival, DIRECTED_ROWS[row].query_time,
                      DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].result);
      wait_for_drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // bursts that fill, drain or mix so both full and empty are reached often
         if (n % 40 == 0)
            mode = $urandom_range(0, 2);
         case (mode)
            0:       begin push_pct = 70; pop_pct = 10; remove_pct = 10; end
            1:       begin push_pct = 15; pop_pct = 55; remove_pct = 20; end
            default: begin push_pct = 40; pop_pct = 25; remove_pct = 20; end
         endcase
         idle_allowed = !(n >= 400 && n < 650);
         if (n % 250 == 249)
            wait_for_drain();

         pick = $urandom_range(0, 99);
         if (pick < push_pct)
            op = OP_PUSH;
         else if (pick < push_pct + pop_pct)
            op = OP_POP;
         else if (pick < push_pct + pop_pct + remove_pct)
            op = OP_REMOVE;
         else
            op = OP_QUERY;

         // small id pool so removes hit and duplicates pile up
         pick = $urandom_range(0, 99);
         if (pick < 8)
            id = 16'h0000;
         else if (pick < 75)
            id = 16'($urandom_range(1, 6));
         else
            id = 16'($urandom_range(0, 65535));
         // narrow ranges make priority and arrival ties common
         prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(0, 255));
         arrival = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 63))
                                               : 16'($urandom_range(0, 65535));
         query_time = ($urandom_range(0, 9) < 4) ? 16'($urandom_range(0, 63))
                                                 : 16'($urandom_range(0, 65535));
         send_request(op, id, prio, arrival, query_time, 1'b0, UNTYPED);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- sim.f -----
design/psfq_pkg.sv
design/psfq_cell.sv
design/priority_select_fifo_queue.sv
sim/priority_select_fifo_queue_tb.sv
